>>> rtl/assert_macros.svh
// assertion helpers used by slrg_datapath
// each macro uses the enclosing module's clock and reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

>>> rtl/slrg_pkg.sv
package slrg_pkg;

   // value and arithmetic widths
   localparam int VALUE_W = 31;
   localparam int MULT_W  = 15;
   localparam int PROD_W  = VALUE_W + MULT_W;

   // generator constants
   localparam logic [VALUE_W-1:0] LEHMER_MOD  = 31'h7FFF_FFFF;
   localparam logic [MULT_W-1:0]  LEHMER_MULT = 15'd16807;
   localparam int                 WARMUP_STEPS = 7;
   localparam int                 TABLE_SIZE_DEFAULT = 32;

   // request command codes
   localparam logic CMD_DRAW   = 1'b0;
   localparam logic CMD_RESEED = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED_MUL,
      ST_SEED_RED,
      ST_SETTLE,
      ST_DRAW_RD,
      ST_DRAW_WB
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_seed;
      logic seed_from_req;
      logic seed_step;
      logic draw_read;
      logic draw_write_back;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic seeded;
      logic step_last;
      logic out_free;
   } status_type;

   // product mod 2^31-1 by folding the high bits onto the low bits
   function automatic logic [VALUE_W-1:0] lehmer_reduce(input logic [PROD_W-1:0] p);
      logic [VALUE_W:0] s;
      s = {1'b0, p[VALUE_W-1:0]} + (VALUE_W+1)'(p[PROD_W-1:VALUE_W]);
      if (s >= {1'b0, LEHMER_MOD}) begin
         s = s - {1'b0, LEHMER_MOD};
      end
      return s[VALUE_W-1:0];
   endfunction

endpackage

>>> rtl/slrg_ctrl.sv
module slrg_ctrl
   import slrg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_command,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               if ((req_command == CMD_RESEED) || !status.seeded) begin
                  cmd.load_seed     = 1'b1;
                  cmd.seed_from_req = (req_command == CMD_RESEED);
                  state_in          = ST_SEED_MUL;
               end else begin
                  state_in = ST_DRAW_RD;
               end
            end
         end
         ST_SEED_MUL: begin
            state_in = ST_SEED_RED;
         end
         ST_SEED_RED: begin
            cmd.seed_step = 1'b1;
            state_in      = status.step_last ? ST_SETTLE : ST_SEED_MUL;
         end
         ST_SETTLE: begin
            state_in = ST_DRAW_RD;
         end
         ST_DRAW_RD: begin
            cmd.draw_read = 1'b1;
            state_in      = ST_DRAW_WB;
         end
         ST_DRAW_WB: begin
            if (status.out_free) begin
               cmd.draw_write_back = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/slrg_datapath.sv
`include "assert_macros.svh"

module slrg_datapath
   import slrg_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [VALUE_W-1:0] req_seed,
   input  cmd_type            cmd,
   output status_type         status,
   output logic               rsp_valid,
   output logic [VALUE_W-1:0] rsp_value,
   input  logic               rsp_stall
);

   // table index is last_output / Ndiv, done as a reciprocal multiply plus one correction
   localparam int    IDX_W   = $clog2(TABLE_SIZE);
   localparam int    STEPS   = TABLE_SIZE + WARMUP_STEPS + 1;
   localparam int    CNT_W   = $clog2(STEPS);
   localparam longint ModInt = 64'd2147483647;
   localparam longint Ndiv   = 1 + (ModInt - 1) / TABLE_SIZE;
   localparam longint Recip  = (64'd1 << 32) / Ndiv;
   localparam int    RECIP_W = $clog2(Recip + 1);
   localparam int    QPROD_W = VALUE_W + RECIP_W;
   localparam int    FIX_W   = VALUE_W + IDX_W;
   localparam logic [VALUE_W-1:0] NDIV_V  = VALUE_W'(Ndiv);
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(Recip);

   logic [VALUE_W-1:0] lehmer_ff, lehmer_in;
   logic [VALUE_W-1:0] last_ff, last_in;
   logic [PROD_W-1:0]  p_ff;
   logic [IDX_W-1:0]   q_ff;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic [VALUE_W-1:0] rd_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] mem [TABLE_SIZE];

   logic [VALUE_W-1:0] reduced;
   logic [VALUE_W-1:0] seed_src;
   logic [VALUE_W-1:0] seed_x0;
   logic [VALUE_W-1:0] q_src;
   logic [QPROD_W-1:0] q_prod;
   logic [FIX_W-1:0]   fix_prod;
   logic [VALUE_W-1:0] rem;
   logic [IDX_W:0]     idx_sum;
   logic [IDX_W-1:0]   idx;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;

   // modular reduction of the registered product
   assign reduced = lehmer_reduce(p_ff);

   // seed start value, zero and the modulus both map to one
   assign seed_src = cmd.seed_from_req ? req_seed : lehmer_ff;
   assign seed_x0  = (seed_src == '0 || seed_src == LEHMER_MOD) ? VALUE_W'(1) : seed_src;

   // index estimate from the value about to become last output
   assign q_src  = cmd.draw_write_back ? rd_ff : last_ff;
   assign q_prod = QPROD_W'(q_src) * QPROD_W'(RECIP_V);

   // estimate is exact or one low, fix it up
   assign fix_prod = FIX_W'(q_ff) * FIX_W'(NDIV_V);
   assign rem      = last_ff - fix_prod[VALUE_W-1:0];
   assign idx_sum  = {1'b0, q_ff} + (IDX_W+1)'(rem >= NDIV_V);
   assign idx      = (idx_sum >= (IDX_W+1)'(TABLE_SIZE)) ? IDX_W'(TABLE_SIZE - 1)
                                                         : idx_sum[IDX_W-1:0];

   // table write port
   assign mem_we    = cmd.draw_read || (cmd.seed_step && step_ff < CNT_W'(TABLE_SIZE));
   assign mem_waddr = cmd.draw_read ? idx : step_ff[IDX_W-1:0];

   // next values of control and generator state
   always_comb begin
      lehmer_in = lehmer_ff;
      if (cmd.load_seed) begin
         lehmer_in = seed_x0;
      end else if (cmd.seed_step || cmd.draw_read) begin
         lehmer_in = reduced;
      end

      last_in = last_ff;
      if (cmd.seed_step && step_ff == '0) begin
         last_in = reduced;
      end else if (cmd.draw_write_back) begin
         last_in = rd_ff;
      end

      step_in = step_ff;
      if (cmd.load_seed) begin
         step_in = CNT_W'(STEPS - 1);
      end else if (cmd.seed_step && step_ff != '0) begin
         step_in = step_ff - CNT_W'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.draw_write_back) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and generator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lehmer_ff    <= VALUE_W'(1);
         last_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lehmer_ff    <= lehmer_in;
         last_ff      <= last_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // multiplier and index estimate stages, free running, and the result register
   always_ff @(posedge clock) begin
      p_ff <= PROD_W'(lehmer_ff) * PROD_W'(LEHMER_MULT);
      q_ff <= q_prod[32 +: IDX_W];
      if (cmd.draw_write_back) begin
         value_ff <= rd_ff;
      end
   end

   // shuffle table, read before write on the same address
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= reduced;
      end
      if (cmd.draw_read) begin
         rd_ff <= mem[idx];
      end
   end

   assign status.seeded    = (last_ff != '0);
   assign status.step_last = (step_ff == '0);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = value_ff;

   `ASSERT_IMPL(a_draw_only_when_seeded, cmd.draw_read, last_ff != '0)
   `ASSERT_IMPL(a_index_in_range, cmd.draw_read, idx_sum < (IDX_W+1)'(TABLE_SIZE))
   `ASSERT_NEXT(a_draw_advances, cmd.draw_read, lehmer_ff != $past(lehmer_ff))
   `ASSERT_NEXT(a_seed_ends_on_entry0, cmd.seed_step && status.step_last, last_ff == lehmer_ff)

endmodule

>>> rtl/shuffled_lehmer_random_generator.sv
// Shuffled minimal-standard random generator: a 16807 * x mod (2^31 - 1) generator
// feeding a shuffle table of TABLE_SIZE entries. Each accepted request returns one
// 31-bit deviate in 1 .. 2^31-2 (divide by 2^31-1 for a uniform real). A draw reads
// the table in the DRAW_RD state, which also does the index lookup and the modular
// reduction of the registered multiply, then loads the result register in DRAW_WB.
// The next request is taken the cycle after, not while a draw is in progress.
// A reseed (command 1, or the first draw after reset, which seeds from the current
// generator value) first runs a SEED_MUL and a SEED_RED state per generator step for
// the 8 warm-up steps and the table fill, then SETTLE. A request is taken while the
// previous result still waits on rsp_stall; that draw then holds until the waiting
// result leaves. Requests stall while reset is high.
module shuffled_lehmer_random_generator
   import slrg_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [VALUE_W-1:0] req_seed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_value
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   slrg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // generator, shuffle table and result register
   slrg_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_seed  (req_seed),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_value (rsp_value),
      .rsp_stall (rsp_stall)
   );

endmodule
